// ----- rtl/psched_pkg.sv -----
package psched_pkg;

    localparam int TASK_SLOTS = 16;
    localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int ID_W       = 4;
    localparam int PRIO_W     = 8;
    localparam int DELAY_W    = 32;
    localparam int ST_W       = 3;
    localparam int OP_W       = 3;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASK_SLOTS - 1);

    // task states
    localparam logic [ST_W-1:0] ST_UNUSED    = 3'd0;
    localparam logic [ST_W-1:0] ST_READY     = 3'd1;
    localparam logic [ST_W-1:0] ST_RUNNING   = 3'd2;
    localparam logic [ST_W-1:0] ST_DELAYED   = 3'd3;
    localparam logic [ST_W-1:0] ST_SUSPENDED = 3'd4;

    // opcodes
    localparam logic [OP_W-1:0] OP_CREATE  = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE  = 3'd1;
    localparam logic [OP_W-1:0] OP_SUSPEND = 3'd2;
    localparam logic [OP_W-1:0] OP_RESUME  = 3'd3;
    localparam logic [OP_W-1:0] OP_YIELD   = 3'd4;
    localparam logic [OP_W-1:0] OP_DELAY   = 3'd5;
    localparam logic [OP_W-1:0] OP_TICK    = 3'd6;
    localparam logic [OP_W-1:0] OP_SCHED   = 3'd7;

    typedef struct packed {
        logic [ST_W-1:0]    state;
        logic [PRIO_W-1:0]  prio;
        logic [DELAY_W-1:0] delay;
    } task_entry_t;

    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        task_entry_t       wr_data;
    } mem_req_t;

    typedef struct packed {
        logic            status;
        logic [ID_W-1:0] task_id;
    } result_t;

endpackage

// ----- rtl/priority_task_scheduler_top.sv -----
// Create (with has_entry set) and schedule walk every slot, one slot per cycle, then write
// the chosen slot in S_FIN; tick walks every slot and goes straight to S_DONE. Single-slot
// ops use S_ISSUE and, to read and modify a slot, S_MOD. One op is in flight at a time: a
// new one is accepted only in idle, after S_DONE has handed its result to the output register.
// Reset: all slots read as unused (per-slot valid flops), no current task,
// output register empty; no clearing pass.
module priority_task_scheduler_top
    import psched_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[2:0], task_id[6:3], priority_req[14:7], has_entry[15], delay_ticks[47:16]
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[0], task_id_res[4:1], zero[7:5]
    output logic [7:0]  m_axis_tdata
);

    mem_req_t    req;
    task_entry_t rd_data;
    logic        res_valid;
    logic        res_ready;
    result_t     res;
    logic        out_valid_reg;
    result_t     out_reg;

    psched_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rd_data (rd_data)
    );

    psched_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .opcode       (s_axis_tdata[2:0]),
        .task_id      (s_axis_tdata[6:3]),
        .priority_req (s_axis_tdata[14:7]),
        .has_entry    (s_axis_tdata[15]),
        .delay_ticks  (s_axis_tdata[47:16]),
        .req          (req),
        .rd_data      (rd_data),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_reg.task_id, out_reg.status};

endmodule

// ----- rtl/psched_mem.sv -----
module psched_mem
    import psched_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  mem_req_t    req,
    output task_entry_t rd_data
);

    task_entry_t           mem [TASK_SLOTS];
    logic [TASK_SLOTS-1:0] valid_reg;
    task_entry_t           rd_raw_reg;
    logic                  rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_raw_reg <= mem[req.rd_addr];
        end
    end

    // an entry never written reads as unused with zero priority and delay
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_raw_reg : '0;

endmodule

// ----- rtl/psched_ctrl.sv -----
module psched_ctrl
    import psched_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [OP_W-1:0]    opcode,
    input  logic [ID_W-1:0]    task_id,
    input  logic [PRIO_W-1:0]  priority_req,
    input  logic               has_entry,
    input  logic [DELAY_W-1:0] delay_ticks,
    output mem_req_t           req,
    input  task_entry_t        rd_data,
    output logic               res_valid,
    input  logic               res_ready,
    output result_t            res
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ISSUE = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [OP_W-1:0]    op_reg, op_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic [PRIO_W-1:0]  prio_reg, prio_next;
    logic               has_reg, has_next;
    logic [DELAY_W-1:0] ticks_reg, ticks_next;
    logic [SLOT_W-1:0]  tgt_reg, tgt_next;
    logic [SLOT_W-1:0]  scan_reg, scan_next;
    logic               found_reg, found_next;
    logic [SLOT_W-1:0]  best_reg, best_next;
    logic [PRIO_W-1:0]  bprio_reg, bprio_next;
    logic [DELAY_W-1:0] bdelay_reg, bdelay_next;
    logic               cur_valid_reg, cur_valid_next;
    logic [SLOT_W-1:0]  cur_reg, cur_next;
    result_t            res_reg, res_next;

    logic               id_ok;
    logic               hit;
    logic [DELAY_W-1:0] dec_delay;

    assign id_ok     = 32'(id_reg) < TASK_SLOTS;
    assign dec_delay = rd_data.delay - 32'd1;
    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        id_next        = id_reg;
        prio_next      = prio_reg;
        has_next       = has_reg;
        ticks_next     = ticks_reg;
        tgt_next       = tgt_reg;
        scan_next      = scan_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        bprio_next     = bprio_reg;
        bdelay_next    = bdelay_reg;
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        res_next       = res_reg;
        req            = '0;
        hit            = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = opcode;
                    id_next    = task_id;
                    prio_next  = priority_req;
                    has_next   = has_entry;
                    ticks_next = delay_ticks;
                    tgt_next   = (opcode == OP_YIELD || opcode == OP_DELAY) ?
                                 cur_reg : SLOT_W'(task_id);
                    state_next = S_ISSUE;
                end
            end

            S_ISSUE:
            begin
                res_next   = '{status: 1'b1, task_id: '0};
                state_next = S_DONE;
                found_next = 1'b0;
                scan_next  = '0;
                unique case (op_reg) inside
                    OP_CREATE, OP_TICK, OP_SCHED:
                    begin
                        if (op_reg != OP_CREATE || has_reg)
                        begin
                            req.rd_en   = 1'b1;
                            req.rd_addr = '0;
                            state_next  = S_SCAN;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (id_ok)
                        begin
                            req.wr_en   = 1'b1;
                            req.wr_addr = tgt_reg;
                            req.wr_data = '0;
                            if (cur_valid_reg && cur_reg == tgt_reg)
                            begin
                                cur_valid_next = 1'b0;
                            end
                            res_next.status = 1'b0;
                        end
                    end
                    OP_SUSPEND, OP_RESUME:
                    begin
                        if (id_ok)
                        begin
                            req.rd_en   = 1'b1;
                            req.rd_addr = tgt_reg;
                            state_next  = S_MOD;
                        end
                    end
                    OP_YIELD:
                    begin
                        if (cur_valid_reg)
                        begin
                            req.rd_en   = 1'b1;
                            req.rd_addr = tgt_reg;
                            state_next  = S_MOD;
                        end
                    end
                    OP_DELAY:
                    begin
                        if (cur_valid_reg && ticks_reg != '0)
                        begin
                            req.rd_en   = 1'b1;
                            req.rd_addr = tgt_reg;
                            state_next  = S_MOD;
                        end
                    end
                endcase
            end

            S_MOD:
            begin
                res_next    = '{status: 1'b1, task_id: '0};
                state_next  = S_DONE;
                req.wr_addr = tgt_reg;
                req.wr_data = rd_data;
                case (op_reg)
                    OP_SUSPEND:
                    begin
                        if (rd_data.state != ST_UNUSED)
                        begin
                            req.wr_en         = 1'b1;
                            req.wr_data.state = ST_SUSPENDED;
                            req.wr_data.delay = '0;
                            if (cur_valid_reg && cur_reg == tgt_reg)
                            begin
                                cur_valid_next = 1'b0;
                            end
                            res_next.status = 1'b0;
                        end
                    end
                    OP_RESUME:
                    begin
                        if (rd_data.state == ST_SUSPENDED)
                        begin
                            req.wr_en         = 1'b1;
                            req.wr_data.state = ST_READY;
                            res_next.status   = 1'b0;
                        end
                    end
                    OP_YIELD:
                    begin
                        if (rd_data.state == ST_RUNNING)
                        begin
                            req.wr_en         = 1'b1;
                            req.wr_data.state = ST_READY;
                            cur_valid_next    = 1'b0;
                            res_next.status   = 1'b0;
                        end
                    end
                    default:
                    begin
                        // delay: park the current task
                        req.wr_en         = 1'b1;
                        req.wr_data.state = ST_DELAYED;
                        req.wr_data.delay = ticks_reg;
                        cur_valid_next    = 1'b0;
                        res_next.status   = 1'b0;
                    end
                endcase
            end

            S_SCAN:
            begin
                // rd_data belongs to slot scan_reg
                case (op_reg)
                    OP_CREATE:
                    begin
                        hit = (rd_data.state == ST_UNUSED) && !found_reg;
                    end
                    OP_SCHED:
                    begin
                        hit = (rd_data.state == ST_READY) &&
                              (!found_reg || rd_data.prio > bprio_reg);
                    end
                    default:
                    begin
                        if (rd_data.state == ST_DELAYED && rd_data.delay != '0)
                        begin
                            req.wr_en         = 1'b1;
                            req.wr_addr       = scan_reg;
                            req.wr_data.prio  = rd_data.prio;
                            req.wr_data.delay = dec_delay;
                            req.wr_data.state = (dec_delay == '0) ? ST_READY : ST_DELAYED;
                        end
                    end
                endcase
                if (hit)
                begin
                    found_next  = 1'b1;
                    best_next   = scan_reg;
                    bprio_next  = rd_data.prio;
                    bdelay_next = rd_data.delay;
                end
                if (scan_reg != LAST_SLOT)
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = scan_reg + 1'b1;
                    scan_next   = scan_reg + 1'b1;
                end
                else if (op_reg == OP_TICK)
                begin
                    res_next   = '{status: 1'b0, task_id: '0};
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                state_next = S_DONE;
                res_next   = '{status: 1'b1, task_id: '0};
                if (found_reg)
                begin
                    req.wr_en   = 1'b1;
                    req.wr_addr = best_reg;
                    res_next    = '{status: 1'b0, task_id: ID_W'(best_reg)};
                    if (op_reg == OP_CREATE)
                    begin
                        req.wr_data = '{state: ST_READY, prio: prio_reg, delay: '0};
                    end
                    else
                    begin
                        req.wr_data    = '{state: ST_RUNNING, prio: bprio_reg,
                                           delay: bdelay_reg};
                        cur_valid_next = 1'b1;
                        cur_next       = best_reg;
                    end
                end
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_valid_reg <= 1'b0;
            cur_reg       <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_valid_reg <= cur_valid_next;
            cur_reg       <= cur_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        id_reg     <= id_next;
        prio_reg   <= prio_next;
        has_reg    <= has_next;
        ticks_reg  <= ticks_next;
        tgt_reg    <= tgt_next;
        scan_reg   <= scan_next;
        best_reg   <= best_next;
        bprio_reg  <= bprio_next;
        bdelay_reg <= bdelay_next;
        res_reg    <= res_next;
    end

endmodule

// ----- rtl/psched_check.sv -----
module psched_check (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [47:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata
);

    logic in_beat;

    assign in_beat = s_axis_tvalid && s_axis_tready;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // a refused op reports slot zero
    a_refused_id: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[4:1] == 4'd0)
        else $error("refused result carries a slot id");

    // one op at a time: no beat right after an accepted one
    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !s_axis_tready)
        else $error("input accepted while an op is in flight");

    // a new result appears only after an op finished, never straight from idle
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared without a finished op");

endmodule

bind priority_task_scheduler_top psched_check u_psched_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
